// ===== rtl/tsft_pkg.sv =====
// Shared types and constants of the topic subscriber fan-out table.
// No dependencies; used by the top level.

package tsft_pkg;

    localparam int KEY_W    = 32;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = IP_W + PORT_W;

    // Most deliver results one publish transfer may produce
    localparam int MAX_RESULTS = 16;

    localparam logic ACT_SUBSCRIBE = 1'b0;
    localparam logic ACT_PUBLISH   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DELIVER    = 3'd0,
        STAT_ADDED      = 3'd1,
        STAT_PRESENT    = 3'd2,
        STAT_TABLE_FULL = 3'd3,
        STAT_LIST_FULL  = 3'd4,
        STAT_UNKNOWN    = 3'd5,
        STAT_NO_SUBS    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOPIC_SCAN,
        ST_DECIDE,
        ST_SUB_SCAN,
        ST_FAN_OUT,
        ST_REPORT
    } state_t;

endpackage

// ===== rtl/tsft_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that updates only on a read strobe. No dependencies.

module tsft_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read strobe
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/topic_subscriber_fanout_table_unit.sv =====
// Topic subscriber fan-out table, top level.
// Depends on tsft_pkg and tsft_ram.

// A subscribe transfer (action 0) looks up its 32-bit topic key, opens a new
// topic slot when the key is new and a slot is free, and appends the
// {sub_ip, sub_port} pair to that topic's list unless the pair is already
// listed or the list is full; it always yields exactly one result with last
// set. A publish transfer (action 1) yields one deliver result per listed
// subscriber up to MAX_RESULTS, in the order they were added, with last on the
// final one, or a single unknown-topic or no-subscribers result. Non-deliver
// results carry zero address and port. One transfer is worked on at a time:
// topic keys and list lengths sit in one RAM, subscriber entries in a second,
// and both have a single read port with registered read data, so a lookup
// walks the topic slots in use at one per cycle. Deliver results go out at one
// per cycle while m_ready stays high. A finished result waits in the output
// register while the next transfer is already taken in. Neither RAM needs
// clearing after reset: only slots below the topic count and entries below a
// list's length are ever read.

module topic_subscriber_fanout_table_unit #(
    parameter int TOPIC_SLOTS    = 16,
    parameter int SUBS_PER_TOPIC = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_topic_key,
    input  logic [31:0] s_sub_ip,
    input  logic [15:0] s_sub_port,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_dest_ip,
    output logic [15:0] m_dest_port,
    output logic        m_last
);

    localparam int TW  = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
    localparam int TFW = $clog2(TOPIC_SLOTS + 1);
    localparam int SFW = $clog2(SUBS_PER_TOPIC + 1);
    localparam int SUB_DEPTH = TOPIC_SLOTS * SUBS_PER_TOPIC;
    localparam int AW  = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
    localparam int TRAM_W = tsft_pkg::KEY_W + SFW;

    localparam logic [TFW-1:0] SLOTS_T = TFW'(TOPIC_SLOTS);
    localparam logic [SFW-1:0] SUBS_S  = SFW'(SUBS_PER_TOPIC);
    localparam logic [AW-1:0]  SUBS_A  = AW'(SUBS_PER_TOPIC);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    tsft_pkg::state_t  state_reg, state_next;
    tsft_pkg::status_t res_status_reg, res_status_next;

    logic [TFW-1:0] topic_fill_reg, topic_fill_next;
    logic [TFW-1:0] tidx_reg, tidx_next;
    logic [TW-1:0]  chk_idx_reg, chk_idx_next;
    logic           chk_vld_reg, chk_vld_next;
    logic           found_reg, found_next;
    logic [TW-1:0]  slot_reg, slot_next;
    logic [SFW-1:0] fill_reg, fill_next;
    logic [SFW-1:0] j_reg, j_next;
    logic [SFW-1:0] n_reg, n_next;

    // Latched input transfer
    logic           act_reg;
    logic [31:0]    key_reg;
    logic [31:0]    ip_reg;
    logic [15:0]    port_reg;

    // Output register
    logic                       m_valid_reg, m_valid_next;
    logic [2:0]                 m_status_reg;
    logic [31:0]                m_dest_ip_reg;
    logic [15:0]                m_dest_port_reg;
    logic                       m_last_reg;

    logic                       out_free;
    logic                       out_load;
    tsft_pkg::status_t          out_status;
    logic [31:0]                out_ip;
    logic [15:0]                out_port;
    logic                       out_last;

    // ---------------------------------------------------------------
    // Memories: topic {key, list length} and subscriber entries
    // ---------------------------------------------------------------
    logic                          tram_we, tram_re;
    logic [TW-1:0]                 tram_waddr, tram_raddr;
    logic [TRAM_W-1:0]             tram_wdata, tram_rdata;
    logic                          sram_we, sram_re;
    logic [AW-1:0]                 sram_waddr, sram_raddr;
    logic [tsft_pkg::ENTRY_W-1:0]  sram_wdata, sram_rdata;

    tsft_ram #(
        .DEPTH (TOPIC_SLOTS),
        .WIDTH (TRAM_W)
    ) u_topic_ram (
        .aclk  (aclk),
        .we    (tram_we),
        .waddr (tram_waddr),
        .wdata (tram_wdata),
        .re    (tram_re),
        .raddr (tram_raddr),
        .rdata (tram_rdata)
    );

    tsft_ram #(
        .DEPTH (SUB_DEPTH),
        .WIDTH (tsft_pkg::ENTRY_W)
    ) u_sub_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .re    (sram_re),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [tsft_pkg::ENTRY_W-1:0] entry;
    logic [AW-1:0]                sub_base;
    logic                         key_hit;
    logic                         entry_hit;
    logic [SFW-1:0]               rd_fill;

    assign entry     = {ip_reg, port_reg};
    assign sub_base  = AW'(slot_reg) * SUBS_A;
    assign key_hit   = (tram_rdata[TRAM_W-1:SFW] == key_reg);
    assign rd_fill   = tram_rdata[SFW-1:0];
    assign entry_hit = (sram_rdata == entry);
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == tsft_pkg::ST_IDLE);
    assign sram_wdata = entry;

    // ---------------------------------------------------------------
    // Sequencer: next state, memory strobes and output load
    // ---------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        topic_fill_next = topic_fill_reg;
        tidx_next       = tidx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        j_next          = j_reg;
        n_next          = n_reg;

        tram_re    = 1'b0;
        tram_raddr = tidx_reg[TW-1:0];
        tram_we    = 1'b0;
        tram_waddr = slot_reg;
        tram_wdata = {key_reg, SFW'(1)};
        sram_re    = 1'b0;
        sram_raddr = sub_base + AW'(j_reg);
        sram_we    = 1'b0;
        sram_waddr = sub_base + AW'(fill_reg);

        out_load   = 1'b0;
        out_status = res_status_reg;
        out_ip     = '0;
        out_port   = '0;
        out_last   = 1'b1;

        unique case (state_reg)
            tsft_pkg::ST_IDLE: begin
                if (s_valid) begin
                    tidx_next    = '0;
                    chk_vld_next = 1'b0;
                    state_next   = tsft_pkg::ST_TOPIC_SCAN;
                end
            end

            // Issue one key read per cycle; compare the word read last cycle
            tsft_pkg::ST_TOPIC_SCAN: begin
                if (chk_vld_reg && key_hit) begin
                    found_next = 1'b1;
                    slot_next  = chk_idx_reg;
                    fill_next  = rd_fill;
                    state_next = tsft_pkg::ST_DECIDE;
                end else if (tidx_reg < topic_fill_reg) begin
                    tram_re      = 1'b1;
                    chk_idx_next = tidx_reg[TW-1:0];
                    chk_vld_next = 1'b1;
                    tidx_next    = tidx_reg + TFW'(1);
                end else begin
                    // Miss: point at the next free slot in case one is opened
                    found_next = 1'b0;
                    slot_next  = topic_fill_reg[TW-1:0];
                    fill_next  = '0;
                    state_next = tsft_pkg::ST_DECIDE;
                end
            end

            tsft_pkg::ST_DECIDE: begin
                j_next       = '0;
                chk_vld_next = 1'b0;
                if (act_reg == tsft_pkg::ACT_PUBLISH) begin
                    if (!found_reg) begin
                        res_status_next = tsft_pkg::STAT_UNKNOWN;
                        state_next      = tsft_pkg::ST_REPORT;
                    end else if (fill_reg == '0) begin
                        res_status_next = tsft_pkg::STAT_NO_SUBS;
                        state_next      = tsft_pkg::ST_REPORT;
                    end else begin
                        // Prefetch the first entry and cap the fan-out
                        sram_re    = 1'b1;
                        sram_raddr = sub_base;
                        j_next     = SFW'(1);
                        if (32'(fill_reg) > 32'(tsft_pkg::MAX_RESULTS)) begin
                            n_next = SFW'(tsft_pkg::MAX_RESULTS);
                        end else begin
                            n_next = fill_reg;
                        end
                        state_next = tsft_pkg::ST_FAN_OUT;
                    end
                end else if (!found_reg) begin
                    if (topic_fill_reg >= SLOTS_T) begin
                        res_status_next = tsft_pkg::STAT_TABLE_FULL;
                    end else begin
                        // Open the topic with this subscriber as its first entry
                        tram_we         = 1'b1;
                        tram_wdata      = {key_reg, SFW'(1)};
                        sram_we         = 1'b1;
                        topic_fill_next = topic_fill_reg + TFW'(1);
                        res_status_next = tsft_pkg::STAT_ADDED;
                    end
                    state_next = tsft_pkg::ST_REPORT;
                end else begin
                    state_next = tsft_pkg::ST_SUB_SCAN;
                end
            end

            // Duplicate search over the matched list, then append if the list has room
            tsft_pkg::ST_SUB_SCAN: begin
                if (chk_vld_reg && entry_hit) begin
                    res_status_next = tsft_pkg::STAT_PRESENT;
                    state_next      = tsft_pkg::ST_REPORT;
                end else if (j_reg < fill_reg) begin
                    sram_re      = 1'b1;
                    chk_vld_next = 1'b1;
                    j_next       = j_reg + SFW'(1);
                end else begin
                    if (fill_reg >= SUBS_S) begin
                        res_status_next = tsft_pkg::STAT_LIST_FULL;
                    end else begin
                        sram_we         = 1'b1;
                        tram_we         = 1'b1;
                        tram_wdata      = {key_reg, fill_reg + SFW'(1)};
                        res_status_next = tsft_pkg::STAT_ADDED;
                    end
                    state_next = tsft_pkg::ST_REPORT;
                end
            end

            // Read data holds entry j-1; advance only when the output is free
            tsft_pkg::ST_FAN_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = tsft_pkg::STAT_DELIVER;
                    out_ip     = sram_rdata[tsft_pkg::ENTRY_W-1:tsft_pkg::PORT_W];
                    out_port   = sram_rdata[tsft_pkg::PORT_W-1:0];
                    out_last   = (j_reg == n_reg);
                    if (j_reg == n_reg) begin
                        state_next = tsft_pkg::ST_IDLE;
                    end else begin
                        sram_re = 1'b1;
                        j_next  = j_reg + SFW'(1);
                    end
                end
            end

            tsft_pkg::ST_REPORT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = tsft_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tsft_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tsft_pkg::ST_IDLE;
            topic_fill_reg <= '0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            topic_fill_reg <= topic_fill_next;
            chk_vld_reg    <= chk_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        tidx_reg       <= tidx_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        fill_reg       <= fill_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            key_reg  <= s_topic_key;
            ip_reg   <= s_sub_ip;
            port_reg <= s_sub_port;
        end
        if (out_load) begin
            m_status_reg    <= out_status;
            m_dest_ip_reg   <= out_ip;
            m_dest_port_reg <= out_port;
            m_last_reg      <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_dest_ip   = m_dest_ip_reg;
    assign m_dest_port = m_dest_port_reg;
    assign m_last      = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_topic_fill_bound : assert property (
        @(posedge aclk) disable iff (!aresetn)
        topic_fill_reg <= SLOTS_T
    ) else $error("topic count exceeds the slot count");

    a_fanout_index : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == tsft_pkg::ST_FAN_OUT) |-> (j_reg != '0) && (j_reg <= n_reg)
    ) else $error("fan-out index out of range");

    a_result_on_finish : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != tsft_pkg::ST_IDLE) ##1 (state_reg == tsft_pkg::ST_IDLE)
            |-> m_valid_reg && m_last_reg
    ) else $error("transfer finished without a final result");

    a_list_len_bound : assert property (
        @(posedge aclk) disable iff (!aresetn)
        tram_we |-> (tram_wdata[SFW-1:0] <= SUBS_S) && (tram_wdata[SFW-1:0] != '0)
    ) else $error("list length written out of range");

endmodule

// ===== bench/tsft_fanout_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the topic subscriber fan-out table: watches both channels,
// predicts each result and compares it. Depends on tsft_pkg.

module tsft_fanout_checker #(
    parameter int TOPIC_SLOTS    = 16,
    parameter int SUBS_PER_TOPIC = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_topic_key,
    input  logic [31:0] s_sub_ip,
    input  logic [15:0] s_sub_port,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_dest_ip,
    input  logic [15:0] m_dest_port,
    input  logic        m_last,
    output int          fail_count,
    output int          expected_left,
    output int          results_checked,
    output int          deliver_cnt,
    output int          added_cnt,
    output int          present_cnt,
    output int          list_full_cnt,
    output int          table_full_cnt,
    output int          unknown_cnt
);

    typedef struct packed {
        tsft_pkg::status_t status;
        logic [31:0]       ip;
        logic [15:0]       port;
        logic              last;
    } fanout_result_t;

    // Shadow copy of the topic table
    logic [31:0]      topic_keys [TOPIC_SLOTS];
    int               topics_used = 0;
    int               list_len [TOPIC_SLOTS];
    logic [47:0]      sub_pairs [TOPIC_SLOTS][SUBS_PER_TOPIC];
    fanout_result_t   due_results [$];
    fanout_result_t   want;

    function automatic int shadow_slot_of(input logic [31:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < topics_used; i++) begin
            if (hit < 0 && topic_keys[i] == key) hit = i;
        end
        return hit;
    endfunction

    function automatic void queue_result(input tsft_pkg::status_t st,
                                         input logic [31:0] ip,
                                         input logic [15:0] port, input logic last);
        fanout_result_t r;
        r.status = st;
        r.ip     = ip;
        r.port   = port;
        r.last   = last;
        due_results.push_back(r);
        case (st)
            tsft_pkg::STAT_DELIVER:    if (last) deliver_cnt++;
            tsft_pkg::STAT_ADDED:      added_cnt++;
            tsft_pkg::STAT_PRESENT:    present_cnt++;
            tsft_pkg::STAT_LIST_FULL:  list_full_cnt++;
            tsft_pkg::STAT_TABLE_FULL: table_full_cnt++;
            tsft_pkg::STAT_UNKNOWN:    unknown_cnt++;
            default: ;
        endcase
    endfunction

    // Update the shadow table for one request and queue what it must produce
    function automatic void route_request(input logic act, input logic [31:0] key,
                                          input logic [31:0] ip, input logic [15:0] port);
        int          slot;
        int          fan;
        bit          dup;
        logic [47:0] pair;
        slot = shadow_slot_of(key);
        pair = {ip, port};
        if (act == tsft_pkg::ACT_SUBSCRIBE) begin
            if (slot < 0 && topics_used >= TOPIC_SLOTS) begin
                queue_result(tsft_pkg::STAT_TABLE_FULL, 32'd0, 16'd0, 1'b1);
            end else begin
                if (slot < 0) begin
                    slot = topics_used;
                    topic_keys[slot] = key;
                    list_len[slot] = 0;
                    topics_used++;
                end
                dup = 1'b0;
                for (int i = 0; i < list_len[slot]; i++) begin
                    if (sub_pairs[slot][i] == pair) dup = 1'b1;
                end
                if (dup) begin
                    queue_result(tsft_pkg::STAT_PRESENT, 32'd0, 16'd0, 1'b1);
                end else if (list_len[slot] >= SUBS_PER_TOPIC) begin
                    queue_result(tsft_pkg::STAT_LIST_FULL, 32'd0, 16'd0, 1'b1);
                end else begin
                    sub_pairs[slot][list_len[slot]] = pair;
                    list_len[slot]++;
                    queue_result(tsft_pkg::STAT_ADDED, 32'd0, 16'd0, 1'b1);
                end
            end
        end else if (slot < 0) begin
            queue_result(tsft_pkg::STAT_UNKNOWN, 32'd0, 16'd0, 1'b1);
        end else begin
            fan = (list_len[slot] > tsft_pkg::MAX_RESULTS) ? tsft_pkg::MAX_RESULTS
                                                           : list_len[slot];
            if (fan == 0) begin
                queue_result(tsft_pkg::STAT_NO_SUBS, 32'd0, 16'd0, 1'b1);
            end else begin
                for (int i = 0; i < fan; i++) begin
                    queue_result(tsft_pkg::STAT_DELIVER, sub_pairs[slot][i][47:16],
                                 sub_pairs[slot][i][15:0], i == fan - 1);
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result status %0d ip %h port %h last %b",
                                 $realtime, m_status, m_dest_ip, m_dest_port, m_last);
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.status || m_dest_ip !== want.ip ||
                        m_dest_port !== want.port || m_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp st %0d ip %h port %h last %b,",
                                      " got st %0d ip %h port %h last %b"},
                                     $realtime, want.status, want.ip, want.port,
                                     want.last, m_status, m_dest_ip, m_dest_port,
                                     m_last);
                    end
                end
            end
            if (s_valid && s_ready)
                route_request(s_action, s_topic_key, s_sub_ip, s_sub_port);
            expected_left = due_results.size();
        end
    end

endmodule

// ===== bench/tb_topic_subscriber_fanout_table_unit.sv =====
`timescale 1ns / 1ps
// Top of the fan-out table bench: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on tsft_pkg, tsft_fanout_checker and the block.

module tb_topic_subscriber_fanout_table_unit;

    localparam int TOPIC_SLOTS    = 16;
    localparam int SUBS_PER_TOPIC = 16;
    localparam int POOL_KEYS      = 22;
    localparam int PAIR_MEM       = 24;
    localparam int RANDOM_ITEMS   = 245;
    localparam int CYCLE_LIMIT    = 600000;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_action    = tsft_pkg::ACT_SUBSCRIBE;
    logic [31:0] s_topic_key = 32'd0;
    logic [31:0] s_sub_ip    = 32'd0;
    logic [15:0] s_sub_port  = 16'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_dest_ip;
    logic [15:0] m_dest_port;
    logic        m_last;

    int fail_count, expected_left, results_checked;
    int deliver_cnt, added_cnt, present_cnt, list_full_cnt, table_full_cnt, unknown_cnt;

    int  cycle_count = 0;
    int  requests_sent = 0;
    int  stall_left = 0;
    // While set, both sides run at full rate with no idling
    bit  full_rate = 1'b0;

    // Topic keys the stimulus draws from; more keys than slots so the table
    // fills up and later new keys are refused.
    logic [31:0] key_pool [POOL_KEYS];
    // Pairs already sent per pool key, reused to provoke duplicates
    logic [47:0] pair_mem [POOL_KEYS][PAIR_MEM];
    int          pair_cnt [POOL_KEYS];

    topic_subscriber_fanout_table_unit #(
        .TOPIC_SLOTS    (TOPIC_SLOTS),
        .SUBS_PER_TOPIC (SUBS_PER_TOPIC)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_topic_key (s_topic_key),
        .s_sub_ip    (s_sub_ip),
        .s_sub_port  (s_sub_port),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_dest_ip   (m_dest_ip),
        .m_dest_port (m_dest_port),
        .m_last      (m_last)
    );

    tsft_fanout_checker #(
        .TOPIC_SLOTS    (TOPIC_SLOTS),
        .SUBS_PER_TOPIC (SUBS_PER_TOPIC)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_topic_key     (s_topic_key),
        .s_sub_ip        (s_sub_ip),
        .s_sub_port      (s_sub_port),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_dest_ip       (m_dest_ip),
        .m_dest_port     (m_dest_port),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked),
        .deliver_cnt     (deliver_cnt),
        .added_cnt       (added_cnt),
        .present_cnt     (present_cnt),
        .list_full_cnt   (list_full_cnt),
        .table_full_cnt  (table_full_cnt),
        .unknown_cnt     (unknown_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_left);
            $display("tb_topic_subscriber_fanout_table_unit: errors");
            $finish;
        end
    end

    // Result side back-pressure: mostly ready, short stalls, now and then a
    // long one. Change at the falling edge so the block sees a settled level.
    always @(negedge aclk) begin
        if (full_rate || !aresetn) begin
            m_ready = aresetn;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  m_ready = 1'b1;
                [70:92]: begin
                    m_ready = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                default: begin
                    m_ready = 1'b0;
                    stall_left = $urandom_range(8, 30);
                end
            endcase
        end
    end

    // Present one request at the falling edge and hold it until the block
    // takes it. Valid stays high on return so back-to-back transfers need no
    // gap; hold_off lowers it when the sender idles.
    task automatic send_request(input logic act, input logic [31:0] key,
                                input logic [31:0] ip, input logic [15:0] port);
        @(negedge aclk);
        s_action    = act;
        s_topic_key = key;
        s_sub_ip    = ip;
        s_sub_port  = port;
        s_valid     = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Stop sending until every outstanding result has been taken
    task automatic drain_results();
        hold_off(1);
        while (expected_left != 0) @(negedge aclk);
    endtask

    // Subscribe to a pool topic and remember the pair for later duplicates
    task automatic subscribe_pool(input int k, input logic [31:0] ip, input logic [15:0] port);
        send_request(tsft_pkg::ACT_SUBSCRIBE, key_pool[k], ip, port);
        if (pair_cnt[k] < PAIR_MEM) begin
            pair_mem[k][pair_cnt[k]] = {ip, port};
            pair_cnt[k]++;
        end else begin
            pair_mem[k][$urandom_range(0, PAIR_MEM - 1)] = {ip, port};
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int          k;
        int          pick;
        logic        act;
        logic [31:0] key;
        logic [31:0] ip;
        logic [15:0] port;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom;
        for (int i = 0; i < POOL_KEYS; i++) pair_cnt[i] = 0;

        // Hold reset, then release it away from the sampling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: publish to an empty table, extremes of key/address/port,
        // a duplicate, a list filled to the brim, then a refused subscriber
        // and a duplicate on the full list (duplicate wins over full).
        send_request(tsft_pkg::ACT_PUBLISH, key_pool[0], 32'hFFFF_FFFF, 16'hFFFF);
        subscribe_pool(0, 32'h0000_0000, 16'h0000);
        subscribe_pool(0, 32'h0000_0000, 16'h0000);
        send_request(tsft_pkg::ACT_PUBLISH, key_pool[0], 32'h0000_0000, 16'h0000);
        subscribe_pool(1, 32'hFFFF_FFFF, 16'hFFFF);
        subscribe_pool(1, 32'h0000_0000, 16'hFFFF);
        send_request(tsft_pkg::ACT_PUBLISH, key_pool[1], $urandom,
                     16'($urandom_range(0, 65535)));
        for (int i = 1; i < SUBS_PER_TOPIC; i++)
            subscribe_pool(0, {8'hA0 + i[7:0], 24'($urandom_range(0, 24'hFF_FFFF))},
                           16'($urandom_range(0, 65535)));
        subscribe_pool(0, 32'h5EED_0001, 16'h1234);
        subscribe_pool(0, 32'h0000_0000, 16'h0000);
        send_request(tsft_pkg::ACT_PUBLISH, key_pool[0], 32'd0, 16'd0);

        drain_results();

        // Random part: mostly traffic on a few hot topics so their lists
        // fill, the rest spread over the pool so the topic table runs out.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            full_rate = (n >= 60 && n < 100);
            if (n == 130) drain_results();

            pick = $urandom_range(0, 99);
            if (pick < 5) k = -1;
            else if (pick < 50) k = $urandom_range(0, 3);
            else k = $urandom_range(0, POOL_KEYS - 1);
            key = (k < 0) ? $urandom : key_pool[k];

            ip   = $urandom;
            port = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                ip = 32'hFFFF_FFFF;
                port = 16'hFFFF;
            end else if (pick < 8) begin
                ip = 32'd0;
                port = 16'd0;
            end

            act = ($urandom_range(0, 99) < 55) ? tsft_pkg::ACT_SUBSCRIBE
                                               : tsft_pkg::ACT_PUBLISH;
            if (act == tsft_pkg::ACT_PUBLISH || k < 0) begin
                send_request(act, key, ip, port);
            end else begin
                // Resend a known pair now and then to hit the duplicate path
                if (pair_cnt[k] > 0 && $urandom_range(0, 99) < 25)
                    {ip, port} = pair_mem[k][$urandom_range(0, pair_cnt[k] - 1)];
                subscribe_pool(k, ip, port);
            end
            hold_off(pick_gap());
        end
        full_rate = 1'b0;

        // Wind down: drop valid, wait for the last results, then watch a
        // while longer for anything the block should not send.
        hold_off(1);
        while (expected_left != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);

        $display("sent %0d requests, checked %0d results, %0d publishes fanned out",
                 requests_sent, results_checked, deliver_cnt);
        $display("added %0d, duplicate %0d, list full %0d, table full %0d, unknown topic %0d",
                 added_cnt, present_cnt, list_full_cnt, table_full_cnt, unknown_cnt);
        if (fail_count == 0 && expected_left == 0) begin
            $display("tb_topic_subscriber_fanout_table_unit: clean");
        end else begin
            $display("tb_topic_subscriber_fanout_table_unit: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tsft_pkg.sv
rtl/tsft_ram.sv
rtl/topic_subscriber_fanout_table_unit.sv
bench/tsft_fanout_checker.sv
bench/tb_topic_subscriber_fanout_table_unit.sv
